// ===== design/nwsc_pkg.sv =====
// Package for the note window score classifier.
// Holds field widths, register indexes, verdict codes and the control structs.
// No dependencies.
package nwsc_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int MEAN_W    = 15;
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 32;

	localparam logic signed [15:0] SCORE_OFFSET = 16'sd300;

	localparam logic [CFG_IDX_W-1:0] REG_FAKE_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_LIMIT = 2'd1;

	localparam logic [SAMPLE_W-1:0] FAKE_LIMIT_RESET   = 12'd4095;
	localparam logic [MEAN_W-1:0]   DOUBLE_LIMIT_RESET = 15'd0;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_GENUINE = 2'd0,
		VERDICT_DOUBLE  = 2'd1,
		VERDICT_FAKE    = 2'd2
	} verdict_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // accumulate the sample triple on the input bus
		logic load;    // load the divider from the window sum and count
		logic step;    // one restoring division step
		logic finish;  // register the result and clear the window
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a new result this cycle
	} dp_status_t;

endpackage

// ===== design/nwsc_ctrl.sv =====
// Controller state machine of the note window score classifier.
// Depends on nwsc_pkg for the command and status structs.
module nwsc_ctrl #(
	parameter int SUM_W = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  nwsc_pkg::dp_status_t status,
	output nwsc_pkg::ctrl_cmd_t  cmd
);
	import nwsc_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [3:0] {
		ST_ACCUM  = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	assign in_ready = (state_q == ST_ACCUM);

	always_comb begin
		cmd        = '0;
		cmd.accept = in_ready && in_valid;
		cmd.load   = (state_q == ST_LOAD);
		cmd.step   = (state_q == ST_DIV);
		cmd.finish = (state_q == ST_FINISH) && status.out_free;
		state_d    = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (cmd.accept && in_last) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == '0) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= STEP_W'(SUM_W - 1);
			end else if (cmd.step && step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/nwsc_datapath.sv =====
// Datapath of the note window score classifier: accumulators, serial divider,
// configuration registers and output register. Depends on nwsc_pkg.
module nwsc_datapath #(
	parameter int MAX_POINTS = 1024,
	parameter int CNT_W      = 11,
	parameter int SUM_W      = 26
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nwsc_pkg::ctrl_cmd_t                 cmd,
	output nwsc_pkg::dp_status_t                status,
	input  logic [nwsc_pkg::SAMPLE_W-1:0]       up_reflect,
	input  logic [nwsc_pkg::SAMPLE_W-1:0]       down_reflect,
	input  logic [nwsc_pkg::SAMPLE_W-1:0]       transmit,
	input  logic                                cfg_write,
	input  logic [nwsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nwsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [nwsc_pkg::VERDICT_W-1:0]      verdict,
	output logic [nwsc_pkg::SAMPLE_W-1:0]       min_transmit,
	output logic signed [nwsc_pkg::MEAN_W-1:0]  mean_score
);
	import nwsc_pkg::*;

	logic [SAMPLE_W-1:0]        fake_limit_q;
	logic signed [MEAN_W-1:0]   double_limit_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [SAMPLE_W-1:0]        min_q;
	logic [CNT_W-1:0]           divisor_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SUM_W-1:0]           quo_q;
	logic                       neg_q;
	logic                       out_valid_q;
	logic [VERDICT_W-1:0]       verdict_q;
	logic [SAMPLE_W-1:0]        min_out_q;
	logic signed [MEAN_W-1:0]   mean_q;

	logic [SAMPLE_W-1:0]        up_c, down_c, tr_c;
	logic signed [15:0]         raw;
	logic signed [15:0]         raw_adj;
	logic signed [MEAN_W-1:0]   score;
	logic [SUM_W-1:0]           sum_mag;
	logic [CNT_W:0]             trial;
	logic [CNT_W:0]             trial_diff;
	logic signed [MEAN_W-1:0]   mean_c;
	logic [VERDICT_W-1:0]       verdict_c;

	// Samples of zero count as one.
	assign up_c   = (up_reflect   == '0) ? SAMPLE_W'(1) : up_reflect;
	assign down_c = (down_reflect == '0) ? SAMPLE_W'(1) : down_reflect;
	assign tr_c   = (transmit     == '0) ? SAMPLE_W'(1) : transmit;

	// Point score (4*T - U - D + 300) / 2, halved toward zero.
	assign raw     = $signed({2'b00, tr_c, 2'b00}) - $signed({4'b0000, up_c})
		- $signed({4'b0000, down_c}) + SCORE_OFFSET;
	assign raw_adj = raw + {15'd0, raw[15]};
	assign score   = raw_adj[15:1];

	assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign trial      = {rem_q, quo_q[SUM_W-1]};
	assign trial_diff = trial - {1'b0, divisor_q};

	assign mean_c = neg_q ? -$signed(quo_q[MEAN_W-1:0]) : $signed(quo_q[MEAN_W-1:0]);

	always_comb begin
		if (min_q > fake_limit_q) begin
			verdict_c = VERDICT_FAKE;
		end else if (mean_c < double_limit_q) begin
			verdict_c = VERDICT_DOUBLE;
		end else begin
			verdict_c = VERDICT_GENUINE;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign min_transmit = min_out_q;
	assign mean_score   = mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fake_limit_q   <= FAKE_LIMIT_RESET;
			double_limit_q <= DOUBLE_LIMIT_RESET;
			sum_q          <= '0;
			count_q        <= '0;
			min_q          <= '1;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FAKE_LIMIT:   fake_limit_q   <= cfg_data[SAMPLE_W-1:0];
					REG_DOUBLE_LIMIT: double_limit_q <= $signed(cfg_data[MEAN_W-1:0]);
					default: ;
				endcase
			end
			if (cmd.accept) begin
				// Once the count saturates, points only feed the minimum.
				if (count_q < CNT_W'(MAX_POINTS)) begin
					sum_q   <= sum_q + SUM_W'(score);
					count_q <= count_q + 1'b1;
				end
				if (tr_c < min_q) min_q <= tr_c;
			end else if (cmd.finish) begin
				sum_q   <= '0;
				count_q <= '0;
				min_q   <= '1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Restoring divider on magnitudes, one quotient bit per step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			divisor_q <= (count_q == '0) ? CNT_W'(1) : count_q;
			rem_q     <= '0;
			quo_q     <= sum_mag;
			neg_q     <= sum_q[SUM_W-1];
		end else if (cmd.step) begin
			if (!trial_diff[CNT_W]) begin
				rem_q <= trial_diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			verdict_q <= verdict_c;
			min_out_q <= min_q;
			mean_q    <= mean_c;
		end
	end

endmodule

// ===== design/note_window_score_classifier_top.sv =====
// Top level of the note window score classifier.
// Instantiates nwsc_ctrl and nwsc_datapath; depends on nwsc_pkg.
//
// The input stream brings one window point per request: upper reflective,
// lower reflective and transmissive samples, with tlast on the final point
// of a window. The block accumulates a score sum, a point count and the least
// transmissive sample while it takes one request per cycle. The point count
// saturates at MAX_POINTS; later points only feed the minimum.
// On the request with tlast the block stops taking input, divides the sum by
// the count in a serial restoring divider that produces one quotient bit per
// cycle, and registers one result request with the verdict, the minimum and
// the mean. After acceptance of the last point the controller passes through
// a load state, SUM_W divide steps and a finish state, which waits until the
// output register is free, before the result is valid. Input intake resumes
// in the cycle after the result is registered.
// The result sits in an output register, so a stalled receiver does not stop
// accumulation of the next window; only the finish of the next window waits
// until the previous result has been taken.
// The configuration channel is always ready and may be written at any time
// the block is idle. Reset clears the window state, drops the output and
// sets fake_limit to 4095 and double_limit to 0.
module note_window_score_classifier_top #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input requests.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [11:0] up_reflect, [23:12] down_reflect, [35:24] transmit, [39:36] zero
	input  logic [nwsc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	input  logic                                  s_axis_tlast,
	// Result requests.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [1:0] verdict, [13:2] min_transmit, [28:14] mean_score, [31:29] zero
	output logic [nwsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// Configuration writes.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nwsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nwsc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import nwsc_pkg::*;

	// The count must hold MAX_POINTS itself; the sum covers MAX_POINTS
	// scores of at most 15 signed bits each.
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = MEAN_W + CNT_W;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	logic [VERDICT_W-1:0]      verdict;
	logic [SAMPLE_W-1:0]       min_transmit;
	logic signed [MEAN_W-1:0]  mean_score;

	assign cfg_ready = 1'b1;

	nwsc_ctrl #(
		.SUM_W (SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	nwsc_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.up_reflect   (s_axis_tdata[11:0]),
		.down_reflect (s_axis_tdata[23:12]),
		.transmit     (s_axis_tdata[35:24]),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.verdict      (verdict),
		.min_transmit (min_transmit),
		.mean_score   (mean_score)
	);

	assign m_axis_tdata = {3'b000, mean_score, min_transmit, verdict};

endmodule

// ===== design/nwsc_checker.sv =====
// Port-level checker for the note window score classifier, bound to the top.
// Depends on nwsc_pkg for field widths and verdict codes.
module nwsc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                s_axis_tlast,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [nwsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import nwsc_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The end of a window closes intake while the division runs.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during window division");

	// Only the three defined verdicts appear.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == VERDICT_GENUINE
			|| m_axis_tdata[1:0] == VERDICT_DOUBLE
			|| m_axis_tdata[1:0] == VERDICT_FAKE))
		else $error("undefined verdict");

	// Clamped samples keep the minimum at one or more; padding stays zero.
	a_min_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[13:2] != 12'd0 && m_axis_tdata[31:29] == 3'd0)
		else $error("bad minimum or padding in result");

endmodule

bind note_window_score_classifier_top nwsc_checker u_nwsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
